@@ rtl/core/twq_pkg.sv @@
package twq_pkg;

  localparam int QueueDepth = 16;
  localparam int MaxResults = 16;
  localparam int TimeW      = 64;
  localparam int IdW        = 8;
  localparam int DurW       = 31;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_WOKEN    = 2'd2,
    KIND_NONE     = 2'd3
  } result_kind_e;

  typedef enum logic {
    REQ_SLEEP = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_RELEASE
  } twq_state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e         op;
    logic [TimeW-1:0] key;
    logic [IdW-1:0]   id;
  } cell_cmd_t;

endpackage

@@ rtl/core/twq_cell.sv @@
module twq_cell (
  input  logic                    clk_i,
  input  twq_pkg::cell_cmd_t      cmd_i,
  input  logic                    occ_i,
  input  logic                    left_le_i,
  input  logic [twq_pkg::TimeW-1:0] left_wake_i,
  input  logic [twq_pkg::IdW-1:0]   left_id_i,
  input  logic [twq_pkg::TimeW-1:0] right_wake_i,
  input  logic [twq_pkg::IdW-1:0]   right_id_i,
  output logic                    le_o,
  output logic [twq_pkg::TimeW-1:0] wake_o,
  output logic [twq_pkg::IdW-1:0]   id_o
);
  import twq_pkg::*;

  logic [TimeW-1:0] wake_q, wake_d;
  logic [IdW-1:0]   id_q, id_d;

  // Occupied and at or before the broadcast key
  assign le_o = occ_i && (wake_q <= cmd_i.key);

  always_comb begin
    wake_d = wake_q;
    id_d   = id_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            wake_d = cmd_i.key;
            id_d   = cmd_i.id;
          end else begin
            wake_d = left_wake_i;
            id_d   = left_id_i;
          end
        end
      end
      CELL_SHIFT: begin
        wake_d = right_wake_i;
        id_d   = right_id_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
    id_q   <= id_d;
  end

  assign wake_o = wake_q;
  assign id_o   = id_q;

endmodule

@@ rtl/core/twq_ctrl.sv @@
module twq_ctrl #(
  parameter int QUEUE_DEPTH = twq_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic                              req_type_i,
  input  logic [twq_pkg::IdW-1:0]           sleeper_id_i,
  input  logic [twq_pkg::DurW-1:0]          duration_i,
  input  logic [twq_pkg::TimeW-1:0]         now_time_i,
  input  logic                              head_le_i,
  input  logic                              next_le_i,
  input  logic [twq_pkg::TimeW-1:0]         head_wake_i,
  input  logic [twq_pkg::IdW-1:0]           head_id_i,
  output twq_pkg::cell_cmd_t                cmd_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  count_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic [1:0]                        res_kind_o,
  output logic [twq_pkg::IdW-1:0]           res_id_o,
  output logic [twq_pkg::TimeW-1:0]         res_wake_o,
  output logic                              res_last_o
);
  import twq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int NumW = $clog2(MaxResults);

  twq_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [TimeW-1:0] when_q, when_d;
  logic [IdW-1:0]   pend_id_q, pend_id_d;

  logic             out_valid_q, out_valid_d;
  result_kind_e     out_kind_q, out_kind_d;
  logic [IdW-1:0]   out_id_q, out_id_d;
  logic [TimeW-1:0] out_wake_q, out_wake_d;
  logic             out_last_q, out_last_d;

  logic slot_free;
  logic accept;
  logic out_load;
  logic rel_last;

  assign slot_free   = !out_valid_q || res_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  // Final release: next cell not due, or the per-tick budget used up
  assign rel_last    = !next_le_i || (num_q == NumW'(MaxResults - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_type_i == REQ_TICK) ? ST_RELEASE : ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RELEASE: begin
        if (slot_free && (!head_le_i || rel_last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result control
  always_comb begin
    count_d    = count_q;
    num_d      = num_q;
    time_d     = time_q;
    when_d     = when_q;
    pend_id_d  = pend_id_q;
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_id_d   = out_id_q;
    out_wake_d = out_wake_q;
    out_last_d = out_last_q;
    cmd_o.op   = CELL_HOLD;
    cmd_o.key  = when_q;
    cmd_o.id   = pend_id_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_TICK) begin
            time_d = now_time_i;
            num_d  = '0;
          end else begin
            when_d    = time_q + TimeW'(duration_i);
            pend_id_d = sleeper_id_i;
          end
        end
      end
      ST_INSERT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_id_d   = '0;
          out_last_d = 1'b1;
          if (count_q == CntW'(QUEUE_DEPTH)) begin
            out_kind_d = KIND_FULL;
            out_wake_d = '0;
          end else begin
            out_kind_d = KIND_ACCEPTED;
            out_wake_d = when_q;
            cmd_o.op   = CELL_INSERT;
            count_d    = count_q + CntW'(1);
          end
        end
      end
      ST_RELEASE: begin
        cmd_o.key = time_q;
        if (slot_free) begin
          out_load = 1'b1;
          if (head_le_i) begin
            out_kind_d = KIND_WOKEN;
            out_id_d   = head_id_i;
            out_wake_d = head_wake_i;
            out_last_d = rel_last;
            cmd_o.op   = CELL_SHIFT;
            count_d    = count_q - CntW'(1);
            num_d      = num_q + NumW'(1);
          end else begin
            out_kind_d = KIND_NONE;
            out_id_d   = '0;
            out_wake_d = '0;
            out_last_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      num_q       <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      num_q       <= num_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    when_q    <= when_d;
    pend_id_q <= pend_id_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_wake_q <= out_wake_d;
      out_last_q <= out_last_d;
    end
  end

  assign count_o     = count_q;
  assign res_valid_o = out_valid_q;
  assign res_kind_o  = out_kind_q;
  assign res_id_o    = out_id_q;
  assign res_wake_o  = out_wake_q;
  assign res_last_o  = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == CELL_INSERT |-> count_q != CntW'(QUEUE_DEPTH))
    else $error("insert into full chain");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == CELL_SHIFT |-> count_q != '0)
    else $error("release from empty chain");

  a_release_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == CELL_SHIFT |=> count_q == $past(count_q) - CntW'(1))
    else $error("count not reduced on release");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || res_ready_i))
    else $error("result register overwritten");
`endif

endmodule

@@ rtl/core/sorted_wakeup_timer_queue_top.sv @@
// Sleep request: accepted in IDLE, then INSERT adds it to the chain, or finds it full,
// and loads the result register. Tick: results leave one per cycle, while the result
// channel takes them, from the head of the cell chain; up to 16 woken results, or a
// single nothing-due result, per tick. One request in flight at a time: the next is
// taken once the last result is in the output register.
// Reset (rst_ni low, asynchronous): queue empty, current time zero, no result pending.
module sorted_wakeup_timer_queue_top #(
  parameter int QUEUE_DEPTH = twq_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // sleeper_id[7:0], duration[38:8], now_time[102:39], pad
  input  logic         s_axis_tuser,  // req_type
  // Result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // woken_id[7:0], wake_at[71:8]
  output logic [1:0]   m_axis_tuser,  // result_kind
  output logic         m_axis_tlast   // last
);
  import twq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cell_cmd_t                        cmd;
  logic [CntW-1:0]                  count;
  logic [QUEUE_DEPTH-1:0]           occ;
  logic [QUEUE_DEPTH-1:0]           le;
  logic [QUEUE_DEPTH-1:0][TimeW-1:0] wake;
  logic [QUEUE_DEPTH-1:0][IdW-1:0]   ids;
  logic [IdW-1:0]                   res_id;
  logic [TimeW-1:0]                 res_wake;

  // Sorted chain: cell 0 holds the earliest wake time. Insert opens a gap by moving
  // later entries one cell right; release moves the whole chain one cell left.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             left_le;
    logic [TimeW-1:0] left_wake;
    logic [IdW-1:0]   left_id;
    logic [TimeW-1:0] right_wake;
    logic [IdW-1:0]   right_id;

    assign occ[i] = (CntW'(i) < count);

    if (i == 0) begin : g_first
      assign left_le   = 1'b1;
      assign left_wake = '0;
      assign left_id   = '0;
    end else begin : g_inner
      assign left_le   = le[i-1];
      assign left_wake = wake[i-1];
      assign left_id   = ids[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_wake = '0;
      assign right_id   = '0;
    end else begin : g_body
      assign right_wake = wake[i+1];
      assign right_id   = ids[i+1];
    end

    twq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_le_i    (left_le),
      .left_wake_i  (left_wake),
      .left_id_i    (left_id),
      .right_wake_i (right_wake),
      .right_id_i   (right_id),
      .le_o         (le[i]),
      .wake_o       (wake[i]),
      .id_o         (ids[i])
    );
  end

  // Sequence requests, count entries and hold the result register
  twq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .sleeper_id_i (s_axis_tdata[7:0]),
    .duration_i   (s_axis_tdata[38:8]),
    .now_time_i   (s_axis_tdata[102:39]),
    .head_le_i    (le[0]),
    .next_le_i    (le[1]),
    .head_wake_i  (wake[0]),
    .head_id_i    (ids[0]),
    .cmd_o        (cmd),
    .count_o      (count),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser),
    .res_id_o     (res_id),
    .res_wake_o   (res_wake),
    .res_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {res_wake, res_id};

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import twq_pkg::*;

  // One request as queued for the driver. A drain marker carries no request: it holds
  // the sender until every predicted response has come back.
  typedef struct {
    bit          drain_mark;
    bit          may_idle;
    req_type_e   kind;
    logic [7:0]  id;
    logic [30:0] dur;
    logic [63:0] now;
  } timer_req_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   id;
    logic [63:0]  wake_at;
    logic         last;
  } timer_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata  = '0;  // sleeper_id[7:0], duration[38:8], now_time[102:39], pad
  logic         s_axis_tuser  = 1'b0;  // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;  // woken_id[7:0], wake_at[71:8]
  logic [1:0]   m_axis_tuser;  // result_kind
  logic         m_axis_tlast;

  sorted_wakeup_timer_queue_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Stimulus backlog and the responses predicted for accepted requests, oldest first
  timer_req_t    req_backlog[$];
  timer_result_t timer_responses_q[$];

  // Shadow of the sleeper queue, kept in wake-time order
  logic [63:0] mdl_wake[QueueDepth];
  logic [7:0]  mdl_owner[QueueDepth];
  int          mdl_count = 0;
  logic [63:0] mdl_now   = '0;

  int n_requests   = 0;  // requests queued for the driver
  int n_accepted   = 0;
  int n_sleeps     = 0;
  int n_ticks      = 0;
  int n_woken      = 0;
  int n_full       = 0;
  int n_none       = 0;
  int n_wrapped    = 0;
  int fail_count   = 0;
  bit calm         = 1'b0;  // no new stalls on the result side start while set
  logic [63:0] gen_now = '0;  // time base of the generated ticks

  // Work out the responses of one accepted request and advance the shadow queue.
  function automatic void predict_timer_response(timer_req_t r);
    timer_result_t res;
    logic [63:0]   due;
    int            pos;
    int            n;
    int            i;
    if (r.kind == REQ_SLEEP) begin
      n_sleeps++;
      due = mdl_now + 64'(r.dur);
      if (due < mdl_now) n_wrapped++;
      if (mdl_count >= QueueDepth) begin
        n_full++;
        res = '{kind: KIND_FULL, id: 8'd0, wake_at: 64'd0, last: 1'b1};
      end else begin
        // Go behind every entry due at the same time or earlier
        pos = 0;
        while (pos < mdl_count && mdl_wake[pos] <= due) pos++;
        for (i = mdl_count; i > pos; i--) begin
          mdl_wake[i]  = mdl_wake[i-1];
          mdl_owner[i] = mdl_owner[i-1];
        end
        mdl_wake[pos]  = due;
        mdl_owner[pos] = r.id;
        mdl_count++;
        res = '{kind: KIND_ACCEPTED, id: 8'd0, wake_at: due, last: 1'b1};
      end
      timer_responses_q.push_back(res);
    end else begin
      n_ticks++;
      mdl_now = r.now;
      n = 0;
      while (n < mdl_count && n < MaxResults && mdl_wake[n] <= mdl_now) n++;
      if (n == 0) begin
        n_none++;
        res = '{kind: KIND_NONE, id: 8'd0, wake_at: 64'd0, last: 1'b1};
        timer_responses_q.push_back(res);
      end else begin
        for (i = 0; i < n; i++) begin
          res = '{kind: KIND_WOKEN, id: mdl_owner[i], wake_at: mdl_wake[i], last: i == n - 1};
          timer_responses_q.push_back(res);
        end
        // Drop the released head entries
        for (i = 0; i < mdl_count - n; i++) begin
          mdl_wake[i]  = mdl_wake[i+n];
          mdl_owner[i] = mdl_owner[i+n];
        end
        mdl_count -= n;
        n_woken   += n;
      end
    end
  endfunction

  // Stimulus builders: the fields a request ignores carry random noise.
  task automatic add_sleep(input logic [7:0] id, input logic [30:0] dur, input bit idle);
    timer_req_t r;
    r = '{drain_mark: 1'b0, may_idle: idle, kind: REQ_SLEEP, id: id, dur: dur,
          now: {$urandom(), $urandom()}};
    req_backlog.push_back(r);
    n_requests++;
  endtask

  task automatic add_tick(input logic [63:0] now, input bit idle);
    timer_req_t r;
    r = '{drain_mark: 1'b0, may_idle: idle, kind: REQ_TICK, id: 8'($urandom()),
          dur: 31'($urandom()), now: now};
    req_backlog.push_back(r);
    n_requests++;
  endtask

  task automatic add_drain();
    timer_req_t r;
    r = '{drain_mark: 1'b1, may_idle: 1'b0, kind: REQ_TICK, id: '0, dur: '0, now: '0};
    req_backlog.push_back(r);
  endtask

  // Driver: present requests from the backlog, hold each until taken, and idle in bursts.
  timer_req_t cur_req;
  int         gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_timer_response(cur_req);
        n_accepted++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until the block takes it
      end else if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (req_backlog[0].drain_mark) begin
        // pause until every predicted response has arrived
        s_axis_tvalid <= 1'b0;
        if (timer_responses_q.size() == 0) void'(req_backlog.pop_front());
      end else if (req_backlog[0].may_idle && $urandom_range(0, 4) == 0) begin
        // idle burst, this cycle included, with the rest counted down in gap_left
        gap_left      <= $urandom_range(0, 10);
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_req        = req_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_req.kind;
        s_axis_tdata  <= {1'b0, cur_req.now, cur_req.dur, cur_req.id};
        calm          <= !cur_req.may_idle;
      end
    end
  end

  // Monitor: check each response against the oldest prediction, stall in bursts.
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: result_kind_e'(m_axis_tuser), id: m_axis_tdata[7:0],
                wake_at: m_axis_tdata[71:8], last: m_axis_tlast};
        if (timer_responses_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected response kind %0d id %0d wake %0h last %0b",
                     $realtime, got.kind, got.id, got.wake_at, got.last);
        end else begin
          want = timer_responses_q.pop_front();
          if (got.kind !== want.kind || got.id !== want.id ||
              got.wake_at !== want.wake_at || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: response mismatch: expected kind %0d id %0d wake %0h last %0b, %s",
                       $realtime, want.kind, want.id, want.wake_at, want.last,
                       $sformatf("got kind %0d id %0d wake %0h last %0b",
                                 got.kind, got.id, got.wake_at, got.last));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left    <= $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int          sel;
    int          k;
    int          j;
    bit          quiet;
    bit          tail;
    logic [30:0] base;

    // Directed part. Empty queue: a tick finds nothing due.
    add_tick(64'd0, 1'b1);
    // Extremes of handle and duration; equal wake times keep arrival order.
    add_sleep(8'd0, 31'd0, 1'b1);
    add_sleep(8'hFF, 31'h7FFF_FFFF, 1'b1);
    add_sleep(8'd5, 31'd0, 1'b1);
    add_tick(64'd0, 1'b1);
    add_tick(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    // Wake time wraps past the top of the time range
    add_sleep(8'd7, 31'h20, 1'b0);
    // Time going back: the wrapped entry is still in the future
    add_tick(64'd3, 1'b1);
    // Fill the queue, with some equal wake times, then overflow it
    for (j = 0; j < 16; j++) add_sleep(8'(j * 17 + 1), 31'(j % 5), j[0]);
    // Everything due at once: the full queue drains in one tick
    add_tick(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_drain();
    gen_now = '1;

    // Random part: mostly sleep bursts followed by ticks that advance time, with noise
    while (n_requests < 260) begin
      tail  = n_requests >= 215;
      quiet = tail || $urandom_range(0, 3) == 0;
      sel   = $urandom_range(0, 99);
      if (sel < 70) begin
        k    = $urandom_range(1, 6);
        base = 31'($urandom_range(0, 20));
        for (j = 0; j < k; j++)
          add_sleep(8'($urandom()), ($urandom_range(0, 2) == 0) ? base : 31'($urandom_range(0, 40)),
                    !quiet);
        k = $urandom_range(1, 3);
        for (j = 0; j < k; j++) begin
          gen_now += 64'($urandom_range(0, 30));
          add_tick(gen_now, !quiet);
        end
      end else if (sel < 80) begin
        add_sleep(8'($urandom()), 31'($urandom()), !quiet);
      end else if (sel < 88) begin
        gen_now = {$urandom(), $urandom()};
        add_tick(gen_now, !quiet);
      end else if (sel < 94) begin
        gen_now -= 64'($urandom_range(0, 60));
        add_tick(gen_now, !quiet);
      end else if (sel < 97) begin
        gen_now = '1;
        add_tick(gen_now, !quiet);
      end else if (!tail) begin
        add_drain();
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every request to be taken and every response to arrive, then a short tail
    do @(negedge clk_i);
    while (n_accepted < n_requests || timer_responses_q.size() != 0);
    repeat (40) @(negedge clk_i);

    $display("Covered %0d sleep requests (%0d refused full, %0d wrapped) and %0d ticks,",
             n_sleeps, n_full, n_wrapped, n_ticks);
    $display("with %0d sleepers woken and %0d ticks finding nothing due; %0d failures.",
             n_woken, n_none, fail_count);
    if (fail_count == 0 && timer_responses_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
